// ===== hw/rtl/tfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types and constants for the tilt fall detector.
// ----------------------------------------------------------------------------
package tfd_pkg;

  localparam int unsigned ANGLE_W  = 13;
  localparam int unsigned LIMIT_W  = 12;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_LOW       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_HIGH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_LIMIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS       = 3'd6;

  // Register reset values
  localparam logic signed [ANGLE_W-1:0] YAW_LOW_RST    = -13'sd320;
  localparam logic signed [ANGLE_W-1:0] YAW_HIGH_RST   = 13'sd1280;
  localparam logic signed [ANGLE_W-1:0] PITCH_LOW_RST  = -13'sd960;
  localparam logic signed [ANGLE_W-1:0] PITCH_HIGH_RST = 13'sd320;
  localparam logic [LIMIT_W-1:0]        ROLL_LIMIT_RST = 12'd1920;
  localparam logic [HOLD_W-1:0]         HOLD_MS_RST    = 16'd2000;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_TILTING = 2'd1,
    MODE_FALLING = 2'd2
  } mode_t;

  typedef struct packed {
    logic                        detect_enable;
    logic signed [ANGLE_W-1:0]   yaw_low;
    logic signed [ANGLE_W-1:0]   yaw_high;
    logic signed [ANGLE_W-1:0]   pitch_low;
    logic signed [ANGLE_W-1:0]   pitch_high;
    logic [LIMIT_W-1:0]          roll_limit;
    logic [HOLD_W-1:0]           hold_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic [TIME_W-1:0]         now_ms;
  } sample_t;

endpackage

// ===== hw/rtl/tfd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tfd_cfg_regs
// Configuration register file, write-only, indexed writes.
// ----------------------------------------------------------------------------
module tfd_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tfd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output tfd_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_enable <= 1'b0;
      cfg.yaw_low       <= tfd_pkg::YAW_LOW_RST;
      cfg.yaw_high      <= tfd_pkg::YAW_HIGH_RST;
      cfg.pitch_low     <= tfd_pkg::PITCH_LOW_RST;
      cfg.pitch_high    <= tfd_pkg::PITCH_HIGH_RST;
      cfg.roll_limit    <= tfd_pkg::ROLL_LIMIT_RST;
      cfg.hold_ms       <= tfd_pkg::HOLD_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tfd_pkg::REG_DETECT_ENABLE: cfg.detect_enable <= cfg_data[0];
        tfd_pkg::REG_YAW_LOW:       cfg.yaw_low    <= cfg_data[tfd_pkg::ANGLE_W-1:0];
        tfd_pkg::REG_YAW_HIGH:      cfg.yaw_high   <= cfg_data[tfd_pkg::ANGLE_W-1:0];
        tfd_pkg::REG_PITCH_LOW:     cfg.pitch_low  <= cfg_data[tfd_pkg::ANGLE_W-1:0];
        tfd_pkg::REG_PITCH_HIGH:    cfg.pitch_high <= cfg_data[tfd_pkg::ANGLE_W-1:0];
        tfd_pkg::REG_ROLL_LIMIT:    cfg.roll_limit <= cfg_data[tfd_pkg::LIMIT_W-1:0];
        tfd_pkg::REG_HOLD_MS:       cfg.hold_ms    <= cfg_data[tfd_pkg::HOLD_W-1:0];
        default: ; // unused index, dropped
      endcase
    end
  end

endmodule

// ===== hw/rtl/tfd_pose_check.sv =====
// ----------------------------------------------------------------------------
// tfd_pose_check
// Window compares on pitch, roll and yaw; flags a pose outside the limits.
// ----------------------------------------------------------------------------
module tfd_pose_check (
  input  tfd_pkg::sample_t sample,
  input  tfd_pkg::cfg_t    cfg,
  output logic             outside
);

  logic signed [tfd_pkg::ANGLE_W:0] roll_ext;
  logic signed [tfd_pkg::ANGLE_W:0] lim_pos;
  logic signed [tfd_pkg::ANGLE_W:0] lim_neg;
  logic roll_out;
  logic yaw_out;
  logic pitch_out;

  // roll limit is unsigned; widen by one bit so both signs fit
  assign roll_ext = {sample.roll_angle[tfd_pkg::ANGLE_W-1], sample.roll_angle};
  assign lim_pos  = {2'b00, cfg.roll_limit};
  assign lim_neg  = -lim_pos;

  assign roll_out  = (roll_ext > lim_pos) || (roll_ext < lim_neg);
  assign yaw_out   = (sample.yaw_angle < cfg.yaw_low) || (sample.yaw_angle > cfg.yaw_high);
  assign pitch_out = (sample.pitch_angle < cfg.pitch_low)
                  || (sample.pitch_angle > cfg.pitch_high);

  assign outside = roll_out || yaw_out || pitch_out;

endmodule

// ===== hw/rtl/tfd_fsm.sv =====
// ----------------------------------------------------------------------------
// tfd_fsm
// Normal / tilting / falling state machine with tilt timestamp and alarm.
// ----------------------------------------------------------------------------
module tfd_fsm (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         detect_enable,
  input  logic                         outside,
  input  logic [tfd_pkg::TIME_W-1:0]   now_ms,
  input  logic [tfd_pkg::HOLD_W-1:0]   hold_ms,
  output tfd_pkg::mode_t               mode_next,
  output logic                         alarm_next
);

  tfd_pkg::mode_t               mode;
  logic [tfd_pkg::TIME_W-1:0]   tilt_start_ms;
  logic [tfd_pkg::TIME_W-1:0]   tilt_start_ms_next;
  logic                         alarm_level;
  logic [tfd_pkg::TIME_W-1:0]   elapsed;
  logic                         hold_expired;

  // elapsed time wraps modulo 2^32
  assign elapsed      = now_ms - tilt_start_ms;
  assign hold_expired = elapsed > {{(tfd_pkg::TIME_W-tfd_pkg::HOLD_W){1'b0}}, hold_ms};

  // next state
  always_comb begin
    mode_next          = mode;
    tilt_start_ms_next = tilt_start_ms;
    if (detect_enable) begin
      unique case (mode)
        tfd_pkg::MODE_TILTING: begin
          if (!outside) mode_next = tfd_pkg::MODE_NORMAL;
          else if (hold_expired) mode_next = tfd_pkg::MODE_FALLING;
        end
        tfd_pkg::MODE_FALLING: begin
          if (!outside) mode_next = tfd_pkg::MODE_NORMAL;
        end
        default: begin
          mode_next = tfd_pkg::MODE_NORMAL;
          if (outside) begin
            mode_next          = tfd_pkg::MODE_TILTING;
            tilt_start_ms_next = now_ms;
          end
        end
      endcase
    end
  end

  // alarm output
  always_comb begin
    alarm_next = alarm_level;
    if (detect_enable) begin
      unique case (mode)
        tfd_pkg::MODE_TILTING: if (outside && hold_expired) alarm_next = 1'b1;
        tfd_pkg::MODE_FALLING: alarm_next = outside;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= tfd_pkg::MODE_NORMAL;
      tilt_start_ms <= '0;
      alarm_level   <= 1'b0;
    end else if (step) begin
      mode          <= mode_next;
      tilt_start_ms <= tilt_start_ms_next;
      alarm_level   <= alarm_next;
    end
  end

endmodule

// ===== hw/rtl/tilt_fall_detector.sv =====
// ----------------------------------------------------------------------------
// tilt_fall_detector
// Attitude-based fall detector: window checks plus a three-state machine.
// Path: a sample passes the input register, then the result register,
//   which holds the state after the step.
// Throughput: one sample per cycle while the result stream is not stalled.
// Reset: synchronous; clears both stages, the state machine and the
//   configuration registers to their defaults.
// ----------------------------------------------------------------------------
module tilt_fall_detector (
  input  logic                               clk,
  input  logic                               rst,
  // sample stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [12:0] pitch_angle, [25:13] roll_angle, [38:26] yaw_angle,
  // [70:39] now_ms, [71] zero
  input  logic [71:0]                        s_tdata,
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [1:0] fall_state, [2] alarm_on, [7:3] zero
  output logic [7:0]                         m_tdata,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [tfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  tfd_pkg::cfg_t    cfg;
  tfd_pkg::sample_t in_sample;   // input register payload
  logic             in_valid;
  logic             outside;
  logic             step;         // sample moves from input reg to result reg
  tfd_pkg::mode_t   mode_next;
  logic             alarm_next;
  tfd_pkg::mode_t   out_state;
  logic             out_alarm;
  logic             out_valid;

  tfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Result register frees up when empty or being drained this cycle.
  assign step     = in_valid && (!out_valid || m_tready);
  // Input register takes a new transfer when empty or moving on.
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample.pitch_angle <= s_tdata[12:0];
      in_sample.roll_angle  <= s_tdata[25:13];
      in_sample.yaw_angle   <= s_tdata[38:26];
      in_sample.now_ms      <= s_tdata[70:39];
    end
  end

  tfd_pose_check u_pose (
    .sample  (in_sample),
    .cfg     (cfg),
    .outside (outside)
  );

  // State advances only on the transfer into the result register, so
  // samples are processed strictly in order, one per cycle unless the output stalls.
  tfd_fsm u_fsm (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .detect_enable (cfg.detect_enable),
    .outside       (outside),
    .now_ms        (in_sample.now_ms),
    .hold_ms       (cfg.hold_ms),
    .mode_next     (mode_next),
    .alarm_next    (alarm_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_state <= mode_next;
      out_alarm <= alarm_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b00000, out_alarm, out_state};

`ifndef NO_ASSERTIONS
  // Alarm tracks the falling state on every delivered result.
  a_alarm_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_alarm == (out_state == tfd_pkg::MODE_FALLING)))
    else $error("alarm does not match falling state");

  // A full pipeline with a stalled output must stop taking samples.
  a_stall_backs_up: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !m_tready) |-> !s_tready)
    else $error("input taken while both stages are stalled");

  // Falling is reached only from tilting.
  a_fall_from_tilt: assert property (@(posedge clk) disable iff (rst)
    (step && out_valid && (out_state == tfd_pkg::MODE_NORMAL))
      |-> (mode_next != tfd_pkg::MODE_FALLING))
    else $error("jump from normal straight to falling");
`endif

endmodule

// ===== test/tb_fall_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fall_pkg
// Scoreboard for the tilt fall detector: shadow registers, a cycle-free
// model of the three-state detector, and an in-order store of the state and
// alarm each accepted sample should produce.
// ----------------------------------------------------------------------------
package tb_fall_pkg;

  import tfd_pkg::*;

  typedef struct packed {
    mode_t state;
    logic  alarm;
  } verdict_t;

  class fall_scoreboard;

    // shadow copy of the register file
    logic                      enable;
    logic signed [ANGLE_W-1:0] yaw_lo, yaw_hi, pitch_lo, pitch_hi;
    logic [LIMIT_W-1:0]        roll_lim;
    logic [HOLD_W-1:0]         hold;

    // detector state
    mode_t                     mode;
    logic [TIME_W-1:0]         tilt_t0;
    logic                      alarm;

    verdict_t                  verdicts[$];
    int unsigned               mismatches;
    int unsigned               checked;
    int unsigned               falls;

    function new();
      enable     = 1'b0;
      yaw_lo     = YAW_LOW_RST;
      yaw_hi     = YAW_HIGH_RST;
      pitch_lo   = PITCH_LOW_RST;
      pitch_hi   = PITCH_HIGH_RST;
      roll_lim   = ROLL_LIMIT_RST;
      hold       = HOLD_MS_RST;
      mode       = MODE_NORMAL;
      tilt_t0    = '0;
      alarm      = 1'b0;
      mismatches = 0;
      checked    = 0;
      falls      = 0;
    endfunction

    // bits above a register's width are dropped, unknown indexes ignored
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DETECT_ENABLE: enable   = val[0];
        REG_YAW_LOW:       yaw_lo   = val[ANGLE_W-1:0];
        REG_YAW_HIGH:      yaw_hi   = val[ANGLE_W-1:0];
        REG_PITCH_LOW:     pitch_lo = val[ANGLE_W-1:0];
        REG_PITCH_HIGH:    pitch_hi = val[ANGLE_W-1:0];
        REG_ROLL_LIMIT:    roll_lim = val[LIMIT_W-1:0];
        REG_HOLD_MS:       hold     = val[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    function bit pose_outside(int pitch, int roll, int yaw);
      int lim, ylo, yhi, plo, phi;
      lim = roll_lim;
      ylo = yaw_lo;
      yhi = yaw_hi;
      plo = pitch_lo;
      phi = pitch_hi;
      return (roll > lim) || (roll < -lim) || (yaw < ylo) || (yaw > yhi) ||
             (pitch < plo) || (pitch > phi);
    endfunction

    function void note_sample(logic signed [ANGLE_W-1:0] pitch,
                              logic signed [ANGLE_W-1:0] roll,
                              logic signed [ANGLE_W-1:0] yaw,
                              logic [TIME_W-1:0] now);
      verdict_t          v;
      logic [TIME_W-1:0] elapsed;
      bit                outside;
      if (enable) begin
        outside = pose_outside(pitch, roll, yaw);
        case (mode)
          MODE_TILTING: begin
            elapsed = now - tilt_t0;
            if (!outside) begin
              mode = MODE_NORMAL;
            end else if (elapsed > hold) begin
              mode  = MODE_FALLING;
              alarm = 1'b1;
            end
          end
          MODE_FALLING: begin
            if (!outside) begin
              mode  = MODE_NORMAL;
              alarm = 1'b0;
            end else begin
              alarm = 1'b1;
            end
          end
          default: begin
            mode = MODE_NORMAL;
            if (outside) begin
              mode    = MODE_TILTING;
              tilt_t0 = now;
            end
          end
        endcase
      end
      v.state = mode;
      v.alarm = alarm;
      verdicts.push_back(v);
    endfunction

    function void check_result(logic [1:0] state, logic alarm_out);
      verdict_t v;
      bit       bad;
      checked++;
      if (verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result state=%0d alarm=%0b with no sample pending",
                   state, alarm_out);
        return;
      end
      v = verdicts.pop_front();
      if (v.state == MODE_FALLING) falls++;
      bad = 1'b0;
      if (state !== v.state) bad = 1'b1;
      if (alarm_out !== v.alarm) bad = 1'b1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d state exp %0d got %0d, alarm exp %0b got %0b",
                   checked, v.state, state, v.alarm, alarm_out);
      end
    endfunction

  endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of tilt_fall_detector. A directed part walks the
// detector through every transition, window boundary, timestamp wrap and the
// disabled hold; random phases then drive tilt episodes (settle, hold a tilt
// across the hold time, recover) plus raw noise under varied register
// settings, with random idling on both sides of the stream.
// ----------------------------------------------------------------------------
module tb_top;

  import tfd_pkg::*;
  import tb_fall_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;   // no-transfer cycles before giving up
  localparam int RX_HOLD_CYCLES  = 120;    // long receiver hold-off
  localparam int N_PHASES        = 9;
  localparam int PHASE_ITEMS     = 185;
  localparam int OFF_ITEMS       = 40;     // short phase with the detector off
  localparam int OFF_PHASE       = 3;
  localparam int HOLDOFF_PHASE   = 4;
  localparam int STEADY_PHASE    = 5;      // no idling on either side
  localparam int WRAP_PHASE      = 6;      // timestamps start just below the wrap
  localparam int ANGLE_MIN       = -4096;  // full 13-bit signed span
  localparam int ANGLE_MAX       = 4095;
  localparam int LIMIT_MAX       = 4095;

  // index past the register list; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  // [12:0] pitch_angle, [25:13] roll_angle, [38:26] yaw_angle,
  // [70:39] now_ms, [71] zero
  logic [71:0]           s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  // [1:0] fall_state, [2] alarm_on, [7:3] zero
  logic [7:0]            m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fall_scoreboard sb = new();

  bit          idle_on;       // random gaps on both sides
  bit          rx_hold_req;   // ask the receiver for one long hold-off
  logic [31:0] clock_ms;      // stimulus millisecond clock
  int          idle_cycles;
  int unsigned sent;
  int unsigned n_settings;

  tilt_fall_detector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitors: everything is sampled at the rising edge, before the NBA updates
  // of that edge land, so transfers are seen exactly as the DUT sees them.
  // Results are checked before the same edge's sample is noted; a result can
  // never belong to a sample accepted on the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata[1:0], m_tdata[2]);
      if (s_tvalid && s_tready)
        sb.note_sample(s_tdata[12:0], s_tdata[25:13], s_tdata[38:26], s_tdata[70:39]);
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Watchdog: any transfer or register write counts as progress
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, sb.verdicts.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready about 80% of cycles, always ready when idling is off, and
  // one long hold-off on request while the sender keeps pushing.
  // --------------------------------------------------------------------------
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!idle_on) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 20);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Value pickers
  // --------------------------------------------------------------------------
  function automatic int pick_range(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // inside [lo, hi], edges favored; an empty window gives a value between hi and lo
  function automatic int pick_in(int lo, int hi);
    if (hi < lo) return pick_range(hi, lo);
    case ($urandom_range(7))
      0:       return lo;
      1:       return hi;
      default: return pick_range(lo, hi);
    endcase
  endfunction

  // outside [lo, hi] within 13 bits, often one step past an edge; a full-span window gives any value
  function automatic int pick_out(int lo, int hi);
    bit lower;
    if (lo <= ANGLE_MIN && hi >= ANGLE_MAX) return pick_range(ANGLE_MIN, ANGLE_MAX);
    lower = (hi >= ANGLE_MAX) || (lo > ANGLE_MIN && $urandom_range(1) == 0);
    if (lower) return $urandom_range(1) ? lo - 1 : pick_range(ANGLE_MIN, lo - 1);
    return $urandom_range(1) ? hi + 1 : pick_range(hi + 1, ANGLE_MAX);
  endfunction

  function automatic cfg_t make_cfg(bit en, int ylo, int yhi, int plo, int phi,
                                    int lim, int hold);
    cfg_t c;
    c.detect_enable = en;
    c.yaw_low       = ANGLE_W'(ylo);
    c.yaw_high      = ANGLE_W'(yhi);
    c.pitch_low     = ANGLE_W'(plo);
    c.pitch_high    = ANGLE_W'(phi);
    c.roll_limit    = LIMIT_W'(lim);
    c.hold_ms       = HOLD_W'(hold);
    return c;
  endfunction

  function automatic cfg_t random_cfg();
    int hold;
    case ($urandom_range(3))
      0:       hold = $urandom_range(8);
      1:       hold = $urandom_range(200);
      2:       hold = $urandom_range(3000);
      default: hold = $urandom_range(65535);
    endcase
    // mostly sane windows around zero; now and then an arbitrary (maybe empty) one
    if ($urandom_range(5) == 0)
      return make_cfg($urandom_range(9) != 0,
                      pick_range(-2880, 2880), pick_range(-2880, 2880),
                      pick_range(-2880, 2880), pick_range(-2880, 2880),
                      $urandom_range(2880), hold);
    return make_cfg($urandom_range(9) != 0,
                    pick_range(-2880, 0), pick_range(0, 2880),
                    pick_range(-2880, 0), pick_range(0, 2880),
                    $urandom_range(2880), hold);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers. All called right after a rising edge; every drive is an NBA.
  // --------------------------------------------------------------------------
  task automatic send_sample(int pitch, int roll, int yaw, logic [31:0] now);
    if (idle_on && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, now, yaw[12:0], roll[12:0], pitch[12:0]};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // stop offering and let every pending result drain out of the pipe
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);   // two-stage pipe, plus margin
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // full register load; junk above each register's width must be dropped
  task automatic program_cfg(cfg_t c);
    logic [15:0] junk;
    junk = $urandom;
    wait_idle();
    put_reg(REG_DETECT_ENABLE, {junk[15:1], c.detect_enable});
    put_reg(REG_YAW_LOW,       {junk[15:13], c.yaw_low});
    put_reg(REG_YAW_HIGH,      {junk[15:13], c.yaw_high});
    put_reg(REG_PITCH_LOW,     {junk[15:13], c.pitch_low});
    put_reg(REG_PITCH_HIGH,    {junk[15:13], c.pitch_high});
    put_reg(REG_ROLL_LIMIT,    {junk[15:12], c.roll_limit});
    put_reg(REG_HOLD_MS,       c.hold_ms);
    put_reg(REG_UNUSED,        junk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // one sample, inside every window or outside on one axis
  task automatic send_pose(cfg_t c, bit outside, int step);
    int lim, p, r, y;
    lim = c.roll_limit;
    p = pick_in(c.pitch_low, c.pitch_high);
    r = pick_in(-lim, lim);
    y = pick_in(c.yaw_low, c.yaw_high);
    if (outside) begin
      case ($urandom_range(2))
        0:       p = pick_out(c.pitch_low, c.pitch_high);
        1:       r = pick_out(-lim, lim);
        default: y = pick_out(c.yaw_low, c.yaw_high);
      endcase
    end
    clock_ms = clock_ms + $urandom_range(step);
    send_sample(p, r, y, clock_ms);
  endtask

  // mostly tilt episodes sized against the hold time, the rest raw noise
  task automatic run_phase(cfg_t c, int n_items);
    int done, run, k, step;
    done = 0;
    step = int'(c.hold_ms) / 3 + 2;
    while (done < n_items) begin
      if ($urandom_range(3) != 0) begin
        run = $urandom_range(3, 1);
        for (k = 0; k < run; k++) send_pose(c, 1'b0, step);
        done += run;
        run = $urandom_range(8, 2);
        for (k = 0; k < run; k++) send_pose(c, 1'b1, step);
        send_pose(c, 1'b0, step);
        done += run + 1;
      end else begin
        send_sample($urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
                    $urandom);
        done++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed walk through the detector
  // --------------------------------------------------------------------------
  task automatic run_directed();
    cfg_t dflt;
    dflt = make_cfg(1'b1, YAW_LOW_RST, YAW_HIGH_RST, PITCH_LOW_RST, PITCH_HIGH_RST,
                    ROLL_LIMIT_RST, HOLD_MS_RST);
    // out of reset the detector is off: outside poses leave it normal
    send_sample(ANGLE_MAX, 0, 0, 32'd0);
    send_sample(0, ANGLE_MAX, ANGLE_MIN, 32'hFFFF_FFFF);

    program_cfg(dflt);
    send_sample(0, 0, 0, 32'd100);
    send_sample(-960, 1920, -320, 32'd110);             // every low edge is inside
    send_sample(320, -1920, 1280, 32'd120);             // every high edge is inside
    send_sample(0, 1921, 0, 32'hFFFF_FFF0);             // roll over -> tilting
    send_sample(0, 0, 0, 32'hFFFF_FFF4);                // back inside -> normal
    send_sample(0, -1921, 0, 32'hFFFF_FFF8);            // roll under -> tilting
    send_sample(0, ANGLE_MIN, 0, 32'd1992);             // elapsed == hold across wrap
    send_sample(0, ANGLE_MAX, 0, 32'd1993);             // elapsed hold+1 -> falling
    send_sample(ANGLE_MIN, 0, 0, 32'd5000);             // stays falling
    send_sample(0, 0, 1281, 32'd5001);
    send_sample(0, 0, 0, 32'd5002);                     // recovery clears alarm
    send_sample(321, 0, 0, 32'd6000);                   // pitch over -> tilting
    send_sample(-961, 0, -321, 32'hFFFF_FFFF);          // huge elapsed -> falling
    send_sample(0, 0, ANGLE_MAX, 32'd0);

    // detector off while falling: an inside pose must not clear the alarm
    program_cfg(make_cfg(1'b0, YAW_LOW_RST, YAW_HIGH_RST, PITCH_LOW_RST,
                         PITCH_HIGH_RST, ROLL_LIMIT_RST, HOLD_MS_RST));
    send_sample(0, 0, 0, 32'd10);

    // empty yaw window: every pose is outside
    program_cfg(make_cfg(1'b1, 100, -100, ANGLE_MIN, ANGLE_MAX, 0, 0));
    send_sample(0, 0, 0, 32'd20);

    // zero hold and zero roll limit: any elapsed time past zero falls
    program_cfg(make_cfg(1'b1, ANGLE_MIN, ANGLE_MAX, ANGLE_MIN, ANGLE_MAX, 0, 0));
    send_sample(0, 0, 0, 32'd21);
    send_sample(0, 1, 0, 32'd22);
    send_sample(0, -1, 0, 32'd22);                      // elapsed zero, still tilting
    send_sample(0, 1, 0, 32'd23);                       // elapsed one -> falling
    send_sample(ANGLE_MIN, 0, ANGLE_MAX, 32'd24);       // full windows, inside
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t c;
    int   ph;
    rst         <= 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    idle_on     = 1'b1;
    rx_hold_req = 1'b0;
    idle_cycles = 0;
    sent        = 0;
    n_settings  = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       c = make_cfg(1'b1, -2880, 2880, -2880, 2880, 2880, 65535);
        1:       c = make_cfg(1'b1, 0, 0, 0, 0, 0, 0);
        2:       c = make_cfg(1'b1, ANGLE_MIN, ANGLE_MAX, ANGLE_MIN, ANGLE_MAX,
                              LIMIT_MAX, 65535);
        default: c = random_cfg();
      endcase
      if (ph == OFF_PHASE) c.detect_enable = 1'b0;
      if (ph > OFF_PHASE) c.detect_enable = 1'b1;
      idle_on  = (ph != STEADY_PHASE);
      clock_ms = (ph == WRAP_PHASE) ? 32'hFFFF_F000 : $urandom;
      // program_cfg first drains: the sender pauses until all results are in
      program_cfg(c);
      if (ph == HOLDOFF_PHASE) rx_hold_req = 1'b1;
      run_phase(c, (ph == OFF_PHASE) ? OFF_ITEMS : PHASE_ITEMS);
    end

    wait_idle();
    repeat (10) @(posedge clk);

    $display("Summary: %0d samples over %0d register settings, %0d results checked",
             sent, n_settings, sb.checked);
    $display("Summary: %0d results in the falling state, %0d mismatches",
             sb.falls, sb.mismatches);
    if (sb.verdicts.size() != 0)
      $display("ERROR: %0d expected results never arrived", sb.verdicts.size());
    if (sb.mismatches == 0 && sb.verdicts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tfd_pkg.sv
hw/rtl/tfd_cfg_regs.sv
hw/rtl/tfd_pose_check.sv
hw/rtl/tfd_fsm.sv
hw/rtl/tilt_fall_detector.sv
test/tb_fall_pkg.sv
test/tb_top.sv
